@@ sv/sap_pkg.sv @@
// Shared constants and types for the signed axis projection pipeline.
// No dependencies.
package sap_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int AXIS_BITS   = 16;
    localparam int VEC_BITS    = 3 * AXIS_BITS;
    localparam int COMP_BITS   = 17;
    localparam int PROD_BITS   = SAMPLE_BITS + AXIS_BITS;
    localparam int DOT_BITS    = PROD_BITS + 2;
    localparam int MAG_BITS    = PROD_BITS;
    localparam int NORM_BITS   = 2 * AXIS_BITS;
    localparam int NUM_BITS    = 2 * MAG_BITS + 2;
    localparam int DIV_STEPS   = NUM_BITS;
    localparam int SQRT_STEPS  = NUM_BITS / 2;
    localparam int ROOT_BITS   = SQRT_STEPS;
    localparam int SREM_BITS   = ROOT_BITS + 2;
    localparam int LANE_LAT    = 3 + DIV_STEPS + SQRT_STEPS + 2;

    localparam logic [ROOT_BITS-1:0] POS_LIMIT = ROOT_BITS'(65535);
    localparam logic [ROOT_BITS-1:0] NEG_LIMIT = ROOT_BITS'(65536);

    typedef enum logic [1:0] {
        REG_UP    = 2'd0,
        REG_FRONT = 2'd1,
        REG_RIGHT = 2'd2,
        REG_NONE  = 2'd3
    } cfg_index_t;

endpackage

@@ sv/sap_lane.sv @@
// One axis lane: dot product, squared norm, restoring divider and square root pipeline.
// Depends on sap_pkg.
module sap_lane (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [sap_pkg::SAMPLE_BITS-1:0] sample_x,
    input  logic signed [sap_pkg::SAMPLE_BITS-1:0] sample_y,
    input  logic signed [sap_pkg::SAMPLE_BITS-1:0] sample_z,
    input  logic        [sap_pkg::VEC_BITS-1:0]    axis_vec,
    output logic signed [sap_pkg::COMP_BITS-1:0]   component,
    output logic                                   axis_zero
);
    import sap_pkg::*;

    logic signed [PROD_BITS-1:0] prod_reg [3];
    logic        [NORM_BITS-1:0] sq_reg   [3];

    logic        [NORM_BITS-1:0] n_reg    [0:DIV_STEPS];
    logic                        neg_reg  [0:DIV_STEPS+SQRT_STEPS+1];
    logic                        zero_reg [0:DIV_STEPS+SQRT_STEPS+1];
    logic        [NUM_BITS-1:0]  num_reg  [0:DIV_STEPS];
    logic        [NORM_BITS-1:0] rem_reg  [0:DIV_STEPS];

    logic        [NUM_BITS-1:0]  rad_reg  [0:SQRT_STEPS];
    logic        [SREM_BITS-1:0] srem_reg [0:SQRT_STEPS];
    logic        [ROOT_BITS-1:0] root_reg [0:SQRT_STEPS];

    logic signed [DOT_BITS-1:0]  dot_reg;
    logic        [NORM_BITS+1:0] norm_sum;
    logic        [NORM_BITS-1:0] norm_reg;
    logic signed [DOT_BITS-1:0]  dot_next;
    logic        [DOT_BITS-1:0]  dot_abs;

    logic        [NUM_BITS-1:0]  num_next  [1:DIV_STEPS];
    logic        [NORM_BITS-1:0] rem_next  [1:DIV_STEPS];
    logic        [NUM_BITS-1:0]  rad_next  [1:SQRT_STEPS];
    logic        [SREM_BITS-1:0] srem_next [1:SQRT_STEPS];
    logic        [ROOT_BITS-1:0] root_next [1:SQRT_STEPS];

    logic        [ROOT_BITS-1:0] mag;
    logic signed [COMP_BITS-1:0] component_next;
    logic signed [COMP_BITS-1:0] component_reg;
    logic                        zero_out_reg;

    always_comb begin
        dot_next = DOT_BITS'(prod_reg[0]) + DOT_BITS'(prod_reg[1]) + DOT_BITS'(prod_reg[2]);
        norm_sum = (NORM_BITS+2)'(sq_reg[0]) + (NORM_BITS+2)'(sq_reg[1])
                 + (NORM_BITS+2)'(sq_reg[2]);
        dot_abs  = dot_reg[DOT_BITS-1] ? DOT_BITS'(-dot_reg) : DOT_BITS'(dot_reg);
    end

    always_comb begin
        logic [NORM_BITS:0] trial;
        logic [NORM_BITS:0] diff;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            trial = {rem_reg[k-1], num_reg[k-1][NUM_BITS-1]};
            diff  = trial - {1'b0, n_reg[k-1]};
            if (trial >= {1'b0, n_reg[k-1]}) begin
                rem_next[k] = diff[NORM_BITS-1:0];
                num_next[k] = {num_reg[k-1][NUM_BITS-2:0], 1'b1};
            end else begin
                rem_next[k] = trial[NORM_BITS-1:0];
                num_next[k] = {num_reg[k-1][NUM_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic [SREM_BITS+1:0] acc;
        logic [SREM_BITS+1:0] test;
        for (int k = 1; k <= SQRT_STEPS; k++) begin
            acc  = {srem_reg[k-1], rad_reg[k-1][NUM_BITS-1 -: 2]};
            test = (SREM_BITS+2)'({root_reg[k-1], 2'b01});
            rad_next[k] = {rad_reg[k-1][NUM_BITS-3:0], 2'b00};
            if (acc >= test) begin
                srem_next[k] = SREM_BITS'(acc - test);
                root_next[k] = {root_reg[k-1][ROOT_BITS-2:0], 1'b1};
            end else begin
                srem_next[k] = SREM_BITS'(acc);
                root_next[k] = {root_reg[k-1][ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        logic [ROOT_BITS:0] rounded;
        rounded = ({1'b0, root_reg[SQRT_STEPS]} + (ROOT_BITS+1)'(1)) >> 1;
        mag     = rounded[ROOT_BITS-1:0];
        if (zero_reg[DIV_STEPS+SQRT_STEPS+1]) begin
            component_next = '0;
        end else if (neg_reg[DIV_STEPS+SQRT_STEPS+1]) begin
            component_next = (mag > NEG_LIMIT) ? COMP_BITS'(-NEG_LIMIT)
                                               : COMP_BITS'(-mag);
        end else begin
            component_next = (mag > POS_LIMIT) ? COMP_BITS'(POS_LIMIT) : COMP_BITS'(mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg[0] <= sample_x * $signed(axis_vec[AXIS_BITS-1:0]);
            prod_reg[1] <= sample_y * $signed(axis_vec[2*AXIS_BITS-1:AXIS_BITS]);
            prod_reg[2] <= sample_z * $signed(axis_vec[3*AXIS_BITS-1:2*AXIS_BITS]);
            sq_reg[0]   <= NORM_BITS'($signed(axis_vec[AXIS_BITS-1:0])
                         * $signed(axis_vec[AXIS_BITS-1:0]));
            sq_reg[1]   <= NORM_BITS'($signed(axis_vec[2*AXIS_BITS-1:AXIS_BITS])
                         * $signed(axis_vec[2*AXIS_BITS-1:AXIS_BITS]));
            sq_reg[2]   <= NORM_BITS'($signed(axis_vec[3*AXIS_BITS-1:2*AXIS_BITS])
                         * $signed(axis_vec[3*AXIS_BITS-1:2*AXIS_BITS]));

            dot_reg  <= dot_next;
            norm_reg <= norm_sum[NORM_BITS-1:0];

            num_reg[0]  <= NUM_BITS'({(2*MAG_BITS)'(dot_abs[MAG_BITS-1:0])
                                      * (2*MAG_BITS)'(dot_abs[MAG_BITS-1:0]), 2'b00});
            rem_reg[0]  <= '0;
            n_reg[0]    <= norm_reg;
            neg_reg[0]  <= dot_reg[DOT_BITS-1];
            zero_reg[0] <= (norm_reg == '0);

            for (int k = 1; k <= DIV_STEPS; k++) begin
                num_reg[k] <= num_next[k];
                rem_reg[k] <= rem_next[k];
                n_reg[k]   <= n_reg[k-1];
            end
            for (int k = 1; k <= DIV_STEPS + SQRT_STEPS + 1; k++) begin
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end

            rad_reg[0]  <= num_reg[DIV_STEPS];
            srem_reg[0] <= '0;
            root_reg[0] <= '0;
            for (int k = 1; k <= SQRT_STEPS; k++) begin
                rad_reg[k]  <= rad_next[k];
                srem_reg[k] <= srem_next[k];
                root_reg[k] <= root_next[k];
            end

            component_reg <= component_next;
            zero_out_reg  <= zero_reg[DIV_STEPS+SQRT_STEPS+1];
        end
    end

    assign component = component_reg;
    assign axis_zero = zero_out_reg;

endmodule

@@ sv/signed_axis_projection_unit.sv @@
// A sample passes the product, sum, divider, square root and output registers before result valid.
// Throughput: one sample per cycle when not stalled; the divider and square root run one bit per stage.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and the three axis registers.
// Top level: configuration registers, valid chain, three sap_lane instances.
// Depends on sap_pkg and sap_lane.
module signed_axis_projection_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [sap_pkg::SAMPLE_BITS-1:0] s_accel_x,
    input  logic signed [sap_pkg::SAMPLE_BITS-1:0] s_accel_y,
    input  logic signed [sap_pkg::SAMPLE_BITS-1:0] s_accel_z,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [sap_pkg::COMP_BITS-1:0]   m_up_component,
    output logic signed [sap_pkg::COMP_BITS-1:0]   m_front_component,
    output logic signed [sap_pkg::COMP_BITS-1:0]   m_right_component,
    output logic                                   m_axis_error,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [1:0]                             cfg_index,
    input  logic [sap_pkg::VEC_BITS-1:0]           cfg_data
);
    import sap_pkg::*;

    logic [VEC_BITS-1:0] up_reg;
    logic [VEC_BITS-1:0] front_reg;
    logic [VEC_BITS-1:0] right_reg;
    logic                vld_reg [0:LANE_LAT-1];
    logic                en;
    logic                up_zero;
    logic                front_zero;
    logic                right_zero;

    assign cfg_ready = 1'b1;
    assign m_valid   = vld_reg[LANE_LAT-1];
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg    <= '0;
            front_reg <= '0;
            right_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                REG_UP:    up_reg    <= cfg_data;
                REG_FRONT: front_reg <= cfg_data;
                REG_RIGHT: right_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LANE_LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < LANE_LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    sap_lane u_up (
        .aclk      (aclk),
        .en        (en),
        .sample_x  (s_accel_x),
        .sample_y  (s_accel_y),
        .sample_z  (s_accel_z),
        .axis_vec  (up_reg),
        .component (m_up_component),
        .axis_zero (up_zero)
    );

    sap_lane u_front (
        .aclk      (aclk),
        .en        (en),
        .sample_x  (s_accel_x),
        .sample_y  (s_accel_y),
        .sample_z  (s_accel_z),
        .axis_vec  (front_reg),
        .component (m_front_component),
        .axis_zero (front_zero)
    );

    sap_lane u_right (
        .aclk      (aclk),
        .en        (en),
        .sample_x  (s_accel_x),
        .sample_y  (s_accel_y),
        .sample_z  (s_accel_z),
        .axis_vec  (right_reg),
        .component (m_right_component),
        .axis_zero (right_zero)
    );

    assign m_axis_error = up_zero || front_zero || right_zero;

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted transfer did not enter the pipeline");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_up_component)
                                   && $stable(m_axis_error)))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule
